>>> hw/rtl/atc_pkg.sv
// Shared types, constants and register codes of the ADC temperature converter.
package atc_pkg;

    localparam int TABLE_ENTRIES_DEF = 141;

    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_CNT_W = 6;

    localparam logic [2:0] REG_SENSOR_MODE = 3'd0;
    localparam logic [2:0] REG_SERIES_OHM  = 3'd1;
    localparam logic [2:0] REG_REF_MV      = 3'd2;
    localparam logic [2:0] REG_SUPPLY_MV   = 3'd3;
    localparam logic [2:0] REG_PT_ZERO     = 3'd4;
    localparam logic [2:0] REG_PT_SLOPE    = 3'd5;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TABLE  = 1'b1;

    localparam logic [9:0] PT_ADC_MIN  = 10'd685;
    localparam logic [9:0] PT_ADC_MAX  = 10'd1000;
    localparam logic [9:0] NTC_ADC_MIN = 10'd130;
    localparam logic [9:0] NTC_ADC_MAX = 10'd990;

    localparam logic [15:0] BAD_TEMP    = 16'd1900;
    localparam logic [15:0] TEMP_OFFSET = 16'd100;
    localparam logic [15:0] TEMP_MAX    = 16'hFFFF;
    localparam logic [4:0]  BAD_RUN_MAX = 5'd20;

    typedef struct packed {
        logic        kind;
        logic [9:0]  adc_sample;
        logic [7:0]  table_index;
        logic [15:0] table_ohm;
    } in_item_t;

    typedef struct packed {
        logic [15:0] temperature_x10;
        logic        sample_bad;
        logic        sensor_fault;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } div_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PT_MUL,
        ST_PT_DEN,
        ST_PT_DIV1,
        ST_PT_DIFF,
        ST_PT_PROD,
        ST_PT_DIV2,
        ST_NTC_MUL,
        ST_NTC_DIV1,
        ST_NTC_RD0,
        ST_NTC_WALK,
        ST_NTC_DIV2,
        ST_DONE
    } state_t;

endpackage

>>> hw/rtl/atc_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
module atc_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  atc_pkg::div_cmd_t                 cmd,
    input  logic [atc_pkg::DIV_NUM_W-1:0]     num,
    input  logic [atc_pkg::DIV_DEN_W-1:0]     den,
    output logic                              done,
    output logic [atc_pkg::DIV_NUM_W-1:0]     quot
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [atc_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [atc_pkg::DIV_DEN_W-1:0]     rem_reg;
    logic [atc_pkg::DIV_DEN_W-1:0]     den_reg;
    logic [atc_pkg::DIV_NUM_W-1:0]     quo_reg;
    logic [atc_pkg::DIV_DEN_W:0]       shifted;
    logic [atc_pkg::DIV_DEN_W+1:0]     trial;
    logic                              ge;
    logic [atc_pkg::DIV_CNT_W:0]       pad;

    assign shifted = {rem_reg, quo_reg[atc_pkg::DIV_NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = ~trial[atc_pkg::DIV_DEN_W+1];
    // The numerator is left aligned so that only nbits steps are needed.
    assign pad     = (atc_pkg::DIV_CNT_W+1)'(atc_pkg::DIV_NUM_W) - {1'b0, cmd.nbits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cmd.nbits;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != (atc_pkg::DIV_CNT_W)'(1));
            done_reg <= (cnt_reg == (atc_pkg::DIV_CNT_W)'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= num << pad;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[atc_pkg::DIV_DEN_W-1:0] : shifted[atc_pkg::DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[atc_pkg::DIV_NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> hw/rtl/adc_temperature_converter.sv
// Top level of the ADC temperature converter: control sequencer, NTC table memory, registers.
// Each request either writes one NTC table entry or converts one ADC sample into a temperature
// in tenths of a degree, and the block works on one request at a time. A table write gives
// no result. A sample outside its window returns 1900. A good Pt1000 sample goes through the
// multiply state, a 47-step pass of the shared one-bit-per-cycle divider, the scaling
// states and a 56-step divider pass. A good NTC sample makes a divider pass and then visits
// at most TABLE_ENTRIES table entries, since the descending table is walked through the
// single read port of the table memory, one entry a cycle. The table has no reset; an entry
// that is never written reads as anything.
// A finished result waits in an output register, so a new request is taken while it waits.
module adc_temperature_converter
#(
    parameter int TABLE_ENTRIES = atc_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  atc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output atc_pkg::out_item_t out_data,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_ENTRIES - 1);
    localparam logic [15:0]   RUNOUT_T  = 16'((TABLE_ENTRIES - 1) * 10);

    // Configuration registers.
    logic        mode_reg;
    logic [15:0] rs_reg;
    logic [12:0] aref_reg;
    logic [12:0] up_reg;
    logic [15:0] r0_reg;
    logic [15:0] slope_reg;

    // Control state.
    atc_pkg::state_t state_reg, state_next;
    logic [4:0]      bad_cnt_reg, bad_cnt_next;
    logic            out_valid_reg, out_valid_next;

    // Datapath registers.
    atc_pkg::out_item_t out_data_reg, out_data_next;
    logic [9:0]  adc_reg, adc_next;
    logic [15:0] res_temp_reg, res_temp_next;
    logic        res_bad_reg, res_bad_next;
    logic        res_fault_reg, res_fault_next;
    logic [28:0] p_ar_reg, p_ar_next;
    logic [22:0] p_aadc_reg, p_aadc_next;
    logic        neg_reg, neg_next;
    logic [40:0] mag_reg, mag_next;
    logic [34:0] plo_reg, plo_next;
    logic [33:0] phi_reg, phi_next;
    logic [15:0] r_reg, r_next;
    logic [15:0] prev_reg, prev_next;
    logic [AW-1:0] walk_i_reg, walk_i_next;
    logic [15:0] base_reg, base_next;

    // NTC table memory.
    logic [15:0]   tbl_mem [TABLE_ENTRIES];
    logic [15:0]   rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          tbl_we;

    // Divider hookup.
    atc_pkg::div_cmd_t                 div_cmd;
    logic [atc_pkg::DIV_NUM_W-1:0]     div_num;
    logic [atc_pkg::DIV_DEN_W-1:0]     div_den;
    logic                              div_done;
    logic [atc_pkg::DIV_NUM_W-1:0]     div_quot;

    // Combinational helpers.
    logic        accept;
    logic        sample_bad;
    logic [5:0]  cnt_inc;
    logic [38:0] pt_num;
    logic [24:0] pt_den;
    logic        pt_den_bad;
    logic [40:0] r256;
    logic [41:0] pt_diff;
    logic [41:0] pt_diff_neg;
    logic [55:0] pt_prod;
    logic [15:0] slope_eff;
    logic [25:0] ntc_num;
    logic [10:0] ntc_den;
    logic [AW:0] next_i;
    logic [15:0] seg_base;
    logic [16:0] ntc_diff;
    logic [16:0] ntc_diff_neg;
    logic [15:0] ntc_mag;
    logic [19:0] ntc_num2;
    logic        out_free;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == atc_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Sample window check and run counter arithmetic.
    assign sample_bad = mode_reg
        ? ((in_data.adc_sample < atc_pkg::NTC_ADC_MIN) || (in_data.adc_sample > atc_pkg::NTC_ADC_MAX))
        : ((in_data.adc_sample < atc_pkg::PT_ADC_MIN) || (in_data.adc_sample > atc_pkg::PT_ADC_MAX));
    assign cnt_inc = {1'b0, bad_cnt_reg} + 6'd1;

    // Pt1000 divider: R256 = Aref*Rs*adc*256 / (1024*Up - Aref*adc).
    assign pt_num     = p_ar_reg * adc_reg;
    assign pt_den     = {2'b00, up_reg, 10'b0} - {2'b00, p_aadc_reg};
    assign pt_den_bad = pt_den[24] || (pt_den == '0);
    // The resistance is capped at 2^40 before the zero offset is removed.
    assign r256 = (div_quot > {15'b0, 1'b1, 40'b0}) ? {1'b1, 40'b0} : div_quot[40:0];
    assign pt_diff     = {1'b0, r256} - {18'b0, r0_reg, 8'b0};
    assign pt_diff_neg = '0 - pt_diff;
    assign pt_prod     = {21'b0, plo_reg} + {1'b0, phi_reg, 21'b0};
    assign slope_eff   = (slope_reg == '0) ? 16'd1 : slope_reg;

    // NTC divider resistance and table interpolation.
    assign ntc_num      = rs_reg * adc_reg;
    assign ntc_den      = 11'd1024 - {1'b0, adc_reg};
    assign next_i       = {1'b0, walk_i_reg} + 1'b1;
    assign seg_base     = 16'(walk_i_reg - 1'b1) * 16'd10;
    assign ntc_diff     = {1'b0, prev_reg} - {1'b0, r_reg};
    assign ntc_diff_neg = '0 - ntc_diff;
    assign ntc_mag      = ntc_diff[16] ? ntc_diff_neg[15:0] : ntc_diff[15:0];
    assign ntc_num2     = {4'b0, ntc_mag} * 20'd10;

    assign tbl_we = accept && (in_data.kind == atc_pkg::KIND_TABLE)
                    && ({1'b0, in_data.table_index} < 9'(TABLE_ENTRIES));

    // Register file writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            rs_reg    <= 16'd2000;
            aref_reg  <= 13'd2500;
            up_reg    <= 13'd5000;
            r0_reg    <= 16'd1000;
            slope_reg <= 16'd3792;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                atc_pkg::REG_SENSOR_MODE: mode_reg  <= cfg_data[0];
                atc_pkg::REG_SERIES_OHM:  rs_reg    <= cfg_data;
                atc_pkg::REG_REF_MV:      aref_reg  <= cfg_data[12:0];
                atc_pkg::REG_SUPPLY_MV:   up_reg    <= cfg_data[12:0];
                atc_pkg::REG_PT_ZERO:     r0_reg    <= cfg_data;
                atc_pkg::REG_PT_SLOPE:    slope_reg <= cfg_data;
                default:                  mode_reg  <= mode_reg;
            endcase
        end
    end

    // Table memory: one write port for table requests, one registered read port for the walk.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[in_data.table_index[AW-1:0]] <= in_data.table_ohm;
        end
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
        end
    end

    atc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Sequencer: next state, datapath updates, divider and memory control.
    always_comb
    begin
        state_next     = state_reg;
        bad_cnt_next   = bad_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        adc_next       = adc_reg;
        res_temp_next  = res_temp_reg;
        res_bad_next   = res_bad_reg;
        res_fault_next = res_fault_reg;
        p_ar_next      = p_ar_reg;
        p_aadc_next    = p_aadc_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        r_next         = r_reg;
        prev_next      = prev_reg;
        walk_i_next    = walk_i_reg;
        base_next      = base_reg;
        div_cmd.start  = 1'b0;
        div_cmd.nbits  = '0;
        div_num        = '0;
        div_den        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            atc_pkg::ST_IDLE:
            begin
                if (accept && (in_data.kind == atc_pkg::KIND_SAMPLE))
                begin
                    adc_next = in_data.adc_sample;
                    if (sample_bad)
                    begin
                        res_temp_next = atc_pkg::BAD_TEMP;
                        res_bad_next  = 1'b1;
                        if (cnt_inc > {1'b0, atc_pkg::BAD_RUN_MAX})
                        begin
                            bad_cnt_next   = atc_pkg::BAD_RUN_MAX;
                            res_fault_next = 1'b1;
                        end
                        else
                        begin
                            bad_cnt_next   = cnt_inc[4:0];
                            res_fault_next = 1'b0;
                        end
                        state_next = atc_pkg::ST_DONE;
                    end
                    else
                    begin
                        bad_cnt_next   = '0;
                        res_bad_next   = 1'b0;
                        res_fault_next = 1'b0;
                        state_next     = mode_reg ? atc_pkg::ST_NTC_MUL : atc_pkg::ST_PT_MUL;
                    end
                end
            end

            atc_pkg::ST_PT_MUL:
            begin
                p_ar_next   = aref_reg * rs_reg;
                p_aadc_next = aref_reg * adc_reg;
                state_next  = atc_pkg::ST_PT_DEN;
            end

            atc_pkg::ST_PT_DEN:
            begin
                if (pt_den_bad)
                begin
                    res_temp_next = atc_pkg::TEMP_MAX;
                    state_next    = atc_pkg::ST_DONE;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                    div_cmd.nbits = 6'd47;
                    div_num       = {9'b0, pt_num, 8'b0};
                    div_den       = pt_den[23:0];
                    state_next    = atc_pkg::ST_PT_DIV1;
                end
            end

            atc_pkg::ST_PT_DIV1:
            begin
                if (div_done)
                begin
                    neg_next   = pt_diff[41];
                    mag_next   = pt_diff[41] ? pt_diff_neg[40:0] : pt_diff[40:0];
                    state_next = atc_pkg::ST_PT_DIFF;
                end
            end

            atc_pkg::ST_PT_DIFF:
            begin
                // The 41-bit magnitude is scaled by 10000 in two halves.
                plo_next   = mag_reg[20:0] * 14'd10000;
                phi_next   = mag_reg[40:21] * 14'd10000;
                state_next = atc_pkg::ST_PT_PROD;
            end

            atc_pkg::ST_PT_PROD:
            begin
                div_cmd.start = 1'b1;
                div_cmd.nbits = 6'd56;
                div_num       = pt_prod;
                div_den       = {slope_eff, 8'b0};
                state_next    = atc_pkg::ST_PT_DIV2;
            end

            atc_pkg::ST_PT_DIV2:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        res_temp_next = (div_quot > 56'd100) ? 16'd0
                                        : atc_pkg::TEMP_OFFSET - div_quot[15:0];
                    end
                    else
                    begin
                        res_temp_next = (div_quot > 56'd65435) ? atc_pkg::TEMP_MAX
                                        : div_quot[15:0] + atc_pkg::TEMP_OFFSET;
                    end
                    state_next = atc_pkg::ST_DONE;
                end
            end

            atc_pkg::ST_NTC_MUL:
            begin
                div_cmd.start = 1'b1;
                div_cmd.nbits = 6'd26;
                div_num       = {30'b0, ntc_num};
                div_den       = {13'b0, ntc_den};
                state_next    = atc_pkg::ST_NTC_DIV1;
            end

            atc_pkg::ST_NTC_DIV1:
            begin
                if (div_done)
                begin
                    r_next     = (div_quot[55:16] != '0) ? 16'hFFFF : div_quot[15:0];
                    state_next = atc_pkg::ST_NTC_RD0;
                end
            end

            atc_pkg::ST_NTC_RD0:
            begin
                rd_en       = 1'b1;
                rd_addr     = '0;
                walk_i_next = '0;
                state_next  = atc_pkg::ST_NTC_WALK;
            end

            atc_pkg::ST_NTC_WALK:
            begin
                // Read data holds the entry at walk_i; the next entry is fetched meanwhile.
                rd_en   = (walk_i_reg != LAST_IDX);
                rd_addr = next_i[AW-1:0];
                if (walk_i_reg == '0)
                begin
                    prev_next   = rd_data_reg;
                    walk_i_next = next_i[AW-1:0];
                end
                else if (r_reg >= rd_data_reg)
                begin
                    base_next = seg_base;
                    if (prev_reg <= rd_data_reg)
                    begin
                        // A flat or rising step stops the walk at the segment start.
                        res_temp_next = seg_base;
                        state_next    = atc_pkg::ST_DONE;
                    end
                    else
                    begin
                        neg_next      = ntc_diff[16];
                        div_cmd.start = 1'b1;
                        div_cmd.nbits = 6'd20;
                        div_num       = {36'b0, ntc_num2};
                        div_den       = {8'b0, prev_reg - rd_data_reg};
                        state_next    = atc_pkg::ST_NTC_DIV2;
                    end
                end
                else if (walk_i_reg == LAST_IDX)
                begin
                    res_temp_next = RUNOUT_T;
                    state_next    = atc_pkg::ST_DONE;
                end
                else
                begin
                    prev_next   = rd_data_reg;
                    walk_i_next = next_i[AW-1:0];
                end
            end

            atc_pkg::ST_NTC_DIV2:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        res_temp_next = (div_quot > {40'b0, base_reg}) ? 16'd0
                                        : base_reg - div_quot[15:0];
                    end
                    else
                    begin
                        res_temp_next = base_reg + div_quot[15:0];
                    end
                    state_next = atc_pkg::ST_DONE;
                end
            end

            atc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.temperature_x10 = res_temp_reg;
                    out_data_next.sample_bad      = res_bad_reg;
                    out_data_next.sensor_fault    = res_fault_reg;
                    state_next                    = atc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = atc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atc_pkg::ST_IDLE;
            bad_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bad_cnt_reg   <= bad_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        adc_reg       <= adc_next;
        res_temp_reg  <= res_temp_next;
        res_bad_reg   <= res_bad_next;
        res_fault_reg <= res_fault_next;
        p_ar_reg      <= p_ar_next;
        p_aadc_reg    <= p_aadc_next;
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        r_reg         <= r_next;
        prev_reg      <= prev_next;
        walk_i_reg    <= walk_i_next;
        base_reg      <= base_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The run counter never passes its saturation value.
    a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
        bad_cnt_reg <= atc_pkg::BAD_RUN_MAX)
        else $error("bad run counter above limit");

    // A fault is only reported on a bad sample.
    a_fault_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_data_reg.sensor_fault || out_data_reg.sample_bad))
        else $error("fault without bad sample");

    // A new result only appears from the completion state.
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == atc_pkg::ST_DONE))
        else $error("result loaded outside completion state");

    // The divider only finishes while the sequencer waits for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == atc_pkg::ST_PT_DIV1 || state_reg == atc_pkg::ST_PT_DIV2 ||
                      state_reg == atc_pkg::ST_NTC_DIV1 || state_reg == atc_pkg::ST_NTC_DIV2))
        else $error("divider finished outside a wait state");

endmodule
